[design/sale_pkg.sv]
// Shared types and codes for the sorted array list engine.
package sale_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT_AT      = 3'd0,
    CMD_DELETE_AT      = 3'd1,
    CMD_INSERT_ORDERED = 3'd2,
    CMD_FIND           = 3'd3,
    CMD_DELETE_VALUE   = 3'd4,
    CMD_CLEAR          = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_BAD_POS   = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_FINISH
  } state_t;

endpackage

[design/sorted_array_list_engine.sv]
// Sorted array list engine: list storage in one memory with a shift/search sequencer.
// Commands that touch no entry (clear, errors) go straight to the result; insert at and
// delete at run one shift pass, and insert ordered, find and delete by value search first,
// then shift (all but find; delete by value only on a hit).
// One command at a time; the next transfer is taken once the sequencer is idle again,
// while the previous result may still be waiting in the output register.
// Reset empties the list at once; entry contents are not cleared.
module sorted_array_list_engine #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [5:0]         found_position,
  output logic signed [31:0] removed_value,
  output logic [6:0]         entry_count
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int PW = (CW > 8) ? CW : 8;

  sale_pkg::state_t  state, state_next, dec_state;
  sale_pkg::status_t st_w, dec_status;

  logic [31:0]        mem [MAX_ENTRIES];
  logic [31:0]        rdata;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data;

  logic [CW-1:0]      count, addr, target, pend_addr;
  logic               pend;
  logic [2:0]         cmd_r;
  logic signed [31:0] val_r;
  logic [5:0]         fpos_w;
  logic [31:0]        rem_w;

  logic               accept, out_free, is_full, is_empty, pos_gt, pos_ge;
  logic               match, srch_more, up_more, dn_more;
  logic [31:0]        cnt32, pa32;

  assign in_ready  = (state == sale_pkg::ST_IDLE) && !rst;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign is_full   = (count == CW'(MAX_ENTRIES));
  assign is_empty  = (count == '0);
  assign pos_gt    = PW'(position) > PW'(count);
  assign pos_ge    = PW'(position) >= PW'(count);
  assign srch_more = addr < count;
  assign dn_more   = addr < count;
  assign up_more   = addr > target;
  assign cnt32     = 32'(count);
  assign pa32      = 32'(pend_addr);

  assign match = pend && ((cmd_r == sale_pkg::CMD_INSERT_ORDERED) ?
                          ($signed(rdata) > val_r) : (rdata == val_r));

  // command decode at transfer
  always_comb begin
    dec_state  = sale_pkg::ST_FINISH;
    dec_status = sale_pkg::STS_OK;
    unique case (command)
      sale_pkg::CMD_INSERT_AT: begin
        if (is_full) dec_status = sale_pkg::STS_FULL;
        else if (pos_gt) dec_status = sale_pkg::STS_BAD_POS;
        else dec_state = sale_pkg::ST_SHIFT_UP;
      end
      sale_pkg::CMD_DELETE_AT: begin
        if (is_empty) dec_status = sale_pkg::STS_EMPTY;
        else if (pos_ge) dec_status = sale_pkg::STS_BAD_POS;
        else dec_state = sale_pkg::ST_SHIFT_DOWN;
      end
      sale_pkg::CMD_INSERT_ORDERED: begin
        if (is_full) dec_status = sale_pkg::STS_FULL;
        else dec_state = sale_pkg::ST_SEARCH;
      end
      sale_pkg::CMD_FIND, sale_pkg::CMD_DELETE_VALUE: begin
        if (is_empty) dec_status = sale_pkg::STS_EMPTY;
        else dec_state = sale_pkg::ST_SEARCH;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sale_pkg::ST_IDLE: begin
        if (accept) state_next = dec_state;
      end
      sale_pkg::ST_SEARCH: begin
        if (match) begin
          if (cmd_r == sale_pkg::CMD_FIND) state_next = sale_pkg::ST_FINISH;
          else if (cmd_r == sale_pkg::CMD_DELETE_VALUE) state_next = sale_pkg::ST_SHIFT_DOWN;
          else state_next = sale_pkg::ST_SHIFT_UP;
        end else if (!srch_more && !pend) begin
          if (cmd_r == sale_pkg::CMD_INSERT_ORDERED) state_next = sale_pkg::ST_SHIFT_UP;
          else state_next = sale_pkg::ST_FINISH;
        end
      end
      sale_pkg::ST_SHIFT_UP: begin
        if (!up_more && !pend) state_next = sale_pkg::ST_FINISH;
      end
      sale_pkg::ST_SHIFT_DOWN: begin
        if (!dn_more && !pend) state_next = sale_pkg::ST_FINISH;
      end
      sale_pkg::ST_FINISH: begin
        if (out_free) state_next = sale_pkg::ST_IDLE;
      end
      default: state_next = sale_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(addr);
    wr_en   = 1'b0;
    wr_addr = AW'(target);
    wr_data = rdata;
    unique case (state)
      sale_pkg::ST_SEARCH: begin
        rd_en = !match && srch_more;
      end
      sale_pkg::ST_SHIFT_UP: begin
        rd_en   = up_more;
        rd_addr = AW'(addr - 1'b1);
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = AW'(pend_addr + 1'b1);
        end else if (!up_more) begin
          wr_en   = 1'b1;
          wr_data = val_r;
        end
      end
      sale_pkg::ST_SHIFT_DOWN: begin
        rd_en   = dn_more;
        wr_en   = pend && (pend_addr != target);
        wr_addr = AW'(pend_addr - 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sale_pkg::ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sale_pkg::ST_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        sale_pkg::ST_IDLE: begin
          pend <= 1'b0;
          if (accept && command == sale_pkg::CMD_CLEAR) count <= '0;
        end
        sale_pkg::ST_SEARCH: begin
          pend <= !match && srch_more;
        end
        sale_pkg::ST_SHIFT_UP: begin
          pend <= up_more;
          if (!up_more && !pend) count <= count + 1'b1;
        end
        sale_pkg::ST_SHIFT_DOWN: begin
          pend <= dn_more;
          if (!dn_more && !pend) count <= count - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    unique case (state)
      sale_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_r  <= command;
          val_r  <= value;
          st_w   <= dec_status;
          fpos_w <= '0;
          rem_w  <= '0;
          target <= CW'(position);
          if (command == sale_pkg::CMD_INSERT_AT) addr <= count;
          else if (command == sale_pkg::CMD_DELETE_AT) addr <= CW'(position);
          else addr <= '0;
        end
      end
      sale_pkg::ST_SEARCH: begin
        if (match) begin
          target <= pend_addr;
          if (cmd_r == sale_pkg::CMD_FIND) fpos_w <= pa32[5:0];
          if (cmd_r == sale_pkg::CMD_DELETE_VALUE) addr <= pend_addr;
          else addr <= count;
        end else if (srch_more) begin
          pend_addr <= addr;
          addr      <= addr + 1'b1;
        end else if (!pend) begin
          if (cmd_r == sale_pkg::CMD_INSERT_ORDERED) begin
            target <= count;
            addr   <= count;
          end else begin
            st_w <= sale_pkg::STS_NOT_FOUND;
          end
        end
      end
      sale_pkg::ST_SHIFT_UP: begin
        if (up_more) begin
          pend_addr <= addr - 1'b1;
          addr      <= addr - 1'b1;
        end
      end
      sale_pkg::ST_SHIFT_DOWN: begin
        if (pend && pend_addr == target && cmd_r == sale_pkg::CMD_DELETE_AT) rem_w <= rdata;
        if (dn_more) begin
          pend_addr <= addr;
          addr      <= addr + 1'b1;
        end
      end
      sale_pkg::ST_FINISH: begin
        if (out_free) begin
          status         <= st_w;
          found_position <= fpos_w;
          removed_value  <= rem_w;
          entry_count    <= cnt32[6:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[dv/sale_list_checker.sv]
// List checker: tracks the engine's command and result transfers, predicts each result and compares.
module sale_list_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         command,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic [5:0]         found_position,
  input  logic signed [31:0] removed_value,
  input  logic [6:0]         entry_count,
  output int                 errors,
  output int                 outstanding
);

  typedef struct {
    sale_pkg::status_t  code;
    logic [5:0]         slot;
    logic signed [31:0] removed;
    logic [6:0]         held;
  } list_result_t;

  logic signed [31:0] slots [MAX_ENTRIES];
  int unsigned        held_count;
  list_result_t       expected_results [$];

  function automatic sale_pkg::status_t put_entry(int unsigned at, logic signed [31:0] v);
    if (held_count >= MAX_ENTRIES) return sale_pkg::STS_FULL;
    if (at > held_count) return sale_pkg::STS_BAD_POS;
    for (int unsigned i = held_count; i > at; i--) slots[i] = slots[i - 1];
    slots[at] = v;
    held_count++;
    return sale_pkg::STS_OK;
  endfunction

  function automatic sale_pkg::status_t take_entry(int unsigned at,
                                                   output logic signed [31:0] old);
    old = '0;
    if (held_count == 0) return sale_pkg::STS_EMPTY;
    if (at >= held_count) return sale_pkg::STS_BAD_POS;
    old = slots[at];
    for (int unsigned i = at + 1; i < held_count; i++) slots[i - 1] = slots[i];
    held_count--;
    return sale_pkg::STS_OK;
  endfunction

  function automatic sale_pkg::status_t locate(logic signed [31:0] v, output int unsigned at);
    at = 0;
    if (held_count == 0) return sale_pkg::STS_EMPTY;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (slots[i] == v) begin
        at = i;
        return sale_pkg::STS_OK;
      end
    end
    return sale_pkg::STS_NOT_FOUND;
  endfunction

  function automatic list_result_t list_apply(logic [2:0] cmd, logic [7:0] pos,
                                              logic signed [31:0] v);
    list_result_t       r;
    int unsigned        at;
    logic signed [31:0] old;
    r.code    = sale_pkg::STS_OK;
    r.slot    = '0;
    r.removed = '0;
    case (cmd)
      sale_pkg::CMD_INSERT_AT: r.code = put_entry(32'(pos), v);
      sale_pkg::CMD_DELETE_AT: begin
        r.code = take_entry(32'(pos), old);
        if (r.code == sale_pkg::STS_OK) r.removed = old;
      end
      sale_pkg::CMD_INSERT_ORDERED: begin
        if (held_count >= MAX_ENTRIES) begin
          r.code = sale_pkg::STS_FULL;
        end else begin
          // before the first strictly greater entry
          at = 0;
          while (at < held_count && !(slots[at] > v)) at++;
          r.code = put_entry(at, v);
        end
      end
      sale_pkg::CMD_FIND: begin
        r.code = locate(v, at);
        if (r.code == sale_pkg::STS_OK) r.slot = at[5:0];
      end
      sale_pkg::CMD_DELETE_VALUE: begin
        r.code = locate(v, at);
        if (r.code == sale_pkg::STS_OK) r.code = take_entry(at, old);
      end
      sale_pkg::CMD_CLEAR: held_count = 0;
      default: ;
    endcase
    r.held = held_count[6:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t exp_r;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(list_apply(command, position, value));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing pending: status %0d count %0d",
                   $time, status, entry_count);
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.code) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.code, status);
          end
          if (found_position !== exp_r.slot) begin
            errors++;
            $display("%0t: found_position expected %0d actual %0d",
                     $time, exp_r.slot, found_position);
          end
          if (removed_value !== exp_r.removed) begin
            errors++;
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, exp_r.removed, removed_value);
          end
          if (entry_count !== exp_r.held) begin
            errors++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp_r.held, entry_count);
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

[dv/tb_sorted_array_list_engine.sv]
// Testbench top for the sorted array list engine: clock, reset, stimulus and verdict.
module tb_sorted_array_list_engine;

  localparam int         MAX_ENTRIES = 64;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         ITEM_TARGET = 800;
  localparam int         QUIET_AFTER = 700;
  localparam int         HOLD_AT     = 200;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         command;
  logic [7:0]         position;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic [5:0]         found_position;
  logic signed [31:0] removed_value;
  logic [6:0]         entry_count;

  int check_errors;
  int results_pending;
  int sent_items;
  int cycle_count;
  bit gaps_on;
  bit stalls_on;
  bit held_off;

  sorted_array_list_engine #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_position(found_position),
    .removed_value(removed_value), .entry_count(entry_count)
  );

  sale_list_checker #(.MAX_ENTRIES(MAX_ENTRIES)) list_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_position(found_position),
    .removed_value(removed_value), .entry_count(entry_count),
    .errors(check_errors), .outstanding(results_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("tb_sorted_array_list_engine NOT OK");
    $finish;
  end

  // result side: random stalls plus one long hold-off so the engine backs up
  initial begin
    int n;
    out_ready = 1'b0;
    held_off  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sent_items >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_op(input logic [2:0] c, input logic [7:0] p,
                         input logic signed [31:0] v);
    int n;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    position <= p;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // small values give duplicates and hits for find and delete by value
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 16) - 8;
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_position(logic [2:0] c);
    int r;
    r = $urandom_range(0, 99);
    if (c == sale_pkg::CMD_INSERT_AT || c == sale_pkg::CMD_DELETE_AT) begin
      if (r < 35) return 8'd0;
      if (r < 85) return 8'($urandom_range(0, MAX_ENTRIES));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_command(phase_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_GROW: begin
        if (r < 45) return sale_pkg::CMD_INSERT_ORDERED;
        if (r < 78) return sale_pkg::CMD_INSERT_AT;
        if (r < 88) return sale_pkg::CMD_FIND;
        if (r < 93) return sale_pkg::CMD_DELETE_VALUE;
        if (r < 98) return sale_pkg::CMD_DELETE_AT;
        return (r == 98) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      PH_SHRINK: begin
        if (r < 40) return sale_pkg::CMD_DELETE_AT;
        if (r < 70) return sale_pkg::CMD_DELETE_VALUE;
        if (r < 82) return sale_pkg::CMD_FIND;
        if (r < 92) return sale_pkg::CMD_INSERT_ORDERED;
        if (r < 98) return sale_pkg::CMD_INSERT_AT;
        return (r == 98) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      default: begin
        if (r < 20) return sale_pkg::CMD_INSERT_ORDERED;
        if (r < 38) return sale_pkg::CMD_INSERT_AT;
        if (r < 56) return sale_pkg::CMD_DELETE_AT;
        if (r < 72) return sale_pkg::CMD_DELETE_VALUE;
        if (r < 92) return sale_pkg::CMD_FIND;
        if (r < 95) return sale_pkg::CMD_CLEAR;
        return (r < 98) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
    endcase
  endfunction

  initial begin
    phase_t     kind;
    int         phase_len;
    logic [2:0] c;
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = '0;
    position   = '0;
    value      = '0;
    sent_items = 0;
    gaps_on    = 1'b0;
    stalls_on  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, bad positions, extremes, hits and misses, spare codes
    send_op(sale_pkg::CMD_DELETE_AT, 8'd0, 32'sd0);
    send_op(sale_pkg::CMD_FIND, 8'd0, 32'sd0);
    send_op(sale_pkg::CMD_DELETE_VALUE, 8'd0, 32'sd0);
    send_op(sale_pkg::CMD_INSERT_AT, 8'd1, 32'sd3);
    send_op(sale_pkg::CMD_INSERT_AT, 8'd0, 32'sh7fffffff);
    send_op(sale_pkg::CMD_INSERT_AT, 8'd1, 32'sh80000000);
    send_op(sale_pkg::CMD_INSERT_ORDERED, 8'd0, 32'sd0);
    send_op(sale_pkg::CMD_INSERT_ORDERED, 8'd0, -32'sd1);
    send_op(sale_pkg::CMD_INSERT_AT, 8'd255, 32'sd5);
    send_op(sale_pkg::CMD_FIND, 8'd0, 32'sh7fffffff);
    send_op(sale_pkg::CMD_FIND, 8'd255, 32'sd12345);
    send_op(sale_pkg::CMD_DELETE_VALUE, 8'd0, 32'sh80000000);
    send_op(sale_pkg::CMD_DELETE_VALUE, 8'd0, 32'sd777);
    send_op(sale_pkg::CMD_DELETE_AT, 8'd3, 32'sd0);
    send_op(sale_pkg::CMD_DELETE_AT, 8'd255, 32'sd0);
    send_op(sale_pkg::CMD_DELETE_AT, 8'd0, 32'sd0);
    send_op(CMD_SPARE_6, 8'd255, -32'sd1);
    send_op(CMD_SPARE_7, 8'd0, 32'sd0);
    send_op(sale_pkg::CMD_FIND, 8'd255, 32'sd0);
    send_op(sale_pkg::CMD_CLEAR, 8'd255, -32'sd1);
    send_op(sale_pkg::CMD_FIND, 8'd0, 32'sd0);
    send_op(sale_pkg::CMD_INSERT_ORDERED, 8'd0, 32'sh80000000);
    send_op(sale_pkg::CMD_CLEAR, 8'd0, 32'sd0);

    kind = PH_GROW;
    while (sent_items < ITEM_TARGET) begin
      phase_len = $urandom_range(40, 120);
      gaps_on   = $urandom_range(0, 2) != 0;
      stalls_on = $urandom_range(0, 2) != 0;
      repeat (phase_len) begin
        if (sent_items >= ITEM_TARGET) break;
        if (sent_items >= QUIET_AFTER) begin
          gaps_on   = 1'b0;
          stalls_on = 1'b0;
        end
        c = pick_command(kind);
        send_op(c, pick_position(c), pick_value());
      end
      kind = phase_t'($urandom_range(0, 2));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (check_errors == 0 && results_pending == 0)
      $display("tb_sorted_array_list_engine OK");
    else
      $display("tb_sorted_array_list_engine NOT OK");
    $finish;
  end

endmodule

[filelist.f]
design/sale_pkg.sv
design/sorted_array_list_engine.sv
dv/sale_list_checker.sv
dv/tb_sorted_array_list_engine.sv
